// ===== rtl/fem_pkg.sv =====
// Shared types, constants and helper functions for the file extent map.
// Used by fem_mem, fem_ctrl and file_extent_map; depends on nothing else.
package fem_pkg;

  localparam int NUM_EXTENTS = 10;
  localparam int ADDR_BITS   = 24;
  localparam int CNT_W       = 8;
  localparam int WORD_W      = ADDR_BITS + CNT_W;
  localparam int LB_W        = 16;
  localparam int PHYS_W      = 24;
  localparam int COUNT_W     = 12;
  localparam int IDX_W       = (NUM_EXTENTS > 1) ? $clog2(NUM_EXTENTS) : 1;
  localparam int SUM_W       = $clog2(NUM_EXTENTS * 255 + 2);
  localparam int CMP_W       = ((SUM_W > LB_W) ? SUM_W : LB_W) + 1;
  localparam int SAT_W       = ((SUM_W + 1) > (COUNT_W + 1)) ? (SUM_W + 1) : (COUNT_W + 1);

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam cnt_t CNT_FULL  = cnt_t'(255);
  localparam cnt_t CNT_EMPTY = cnt_t'(255);
  localparam idx_t LAST_IDX  = idx_t'(NUM_EXTENTS - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_APPEND = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_NO_ROOM   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_APPLY,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  wr_en;
    idx_t  wr_addr;
    word_t wr_data;
  } mem_req_t;

  typedef struct packed {
    status_t             status;
    logic [PHYS_W-1:0]   phys;
    logic [COUNT_W-1:0]  count;
  } res_t;

  function automatic addr_t ext_start(word_t w);
    return w[ADDR_BITS-1:0];
  endfunction

  function automatic cnt_t ext_len(word_t w);
    cnt_t code;
    code = w[WORD_W-1:ADDR_BITS];
    if (w[ADDR_BITS-1:0] == '0 || code == CNT_EMPTY) begin
      return '0;
    end
    return code + cnt_t'(1);
  endfunction

  function automatic word_t ext_pack(addr_t start, cnt_t code);
    return {code, start};
  endfunction

  function automatic logic [PHYS_W-1:0] to_phys(addr_t a);
    logic [ADDR_BITS+PHYS_W-1:0] t;
    t = {{PHYS_W{1'b0}}, a};
    return t[PHYS_W-1:0];
  endfunction

  function automatic addr_t from_phys(logic [PHYS_W-1:0] p);
    logic [ADDR_BITS+PHYS_W-1:0] t;
    t = {{ADDR_BITS{1'b0}}, p};
    return t[ADDR_BITS-1:0];
  endfunction

endpackage

// ===== rtl/fem_mem.sv =====
// Extent table storage: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as empty after reset.
// Depends on fem_pkg.
module fem_mem (
  input  logic              clk,
  input  logic              rst,
  input  fem_pkg::mem_req_t req,
  output fem_pkg::word_t    rd_data
);

  fem_pkg::word_t                   mem [fem_pkg::NUM_EXTENTS];
  logic [fem_pkg::NUM_EXTENTS-1:0]  valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= valid[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

endmodule

// ===== rtl/fem_ctrl.sv =====
// Sequencer that walks the extent table one entry per cycle for lookup
// and append; an append then writes back the modified or new extent. Depends on fem_pkg.
module fem_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [fem_pkg::LB_W-1:0]      logical_block,
  input  logic [fem_pkg::PHYS_W-1:0]    new_block,
  input  logic                          out_free,
  output logic                          res_valid,
  output fem_pkg::res_t                 res,
  output fem_pkg::mem_req_t             mem_req,
  input  fem_pkg::word_t                rd_data
);

  fem_pkg::state_t                  state, state_next;
  logic                             act, act_next;
  logic [fem_pkg::LB_W-1:0]         blk, blk_next;
  fem_pkg::addr_t                   nr, nr_next;
  fem_pkg::idx_t                    k, k_next;
  fem_pkg::sum_t                    sum, sum_next;
  fem_pkg::word_t                   prev, prev_next;
  fem_pkg::idx_t                    tgt_idx, tgt_idx_next;
  fem_pkg::word_t                   tgt_word, tgt_word_next;
  fem_pkg::res_t                    res_next;

  fem_pkg::cnt_t                    cur_len;
  fem_pkg::cnt_t                    prev_len;
  fem_pkg::cnt_t                    tgt_len;
  fem_pkg::sum_t                    sum_cur;
  logic [fem_pkg::CMP_W-1:0]        blk_ext, sum_ext, end_ext, diff;
  fem_pkg::addr_t                   hit_addr;
  logic [fem_pkg::ADDR_BITS:0]      contig_end;
  logic [fem_pkg::SAT_W-1:0]        total;
  logic [fem_pkg::COUNT_W-1:0]      total_sat;

  assign cur_len    = fem_pkg::ext_len(rd_data);
  assign prev_len   = fem_pkg::ext_len(prev);
  assign tgt_len    = fem_pkg::ext_len(tgt_word);
  assign sum_cur    = sum + fem_pkg::SUM_W'(cur_len);
  assign blk_ext    = fem_pkg::CMP_W'(blk);
  assign sum_ext    = fem_pkg::CMP_W'(sum);
  assign end_ext    = sum_ext + fem_pkg::CMP_W'(cur_len);
  assign diff       = blk_ext - sum_ext;
  assign hit_addr   = fem_pkg::ext_start(rd_data)
                    + fem_pkg::ADDR_BITS'(diff[fem_pkg::CNT_W-1:0]);
  assign contig_end = {1'b0, fem_pkg::ext_start(tgt_word)}
                    + (fem_pkg::ADDR_BITS + 1)'(tgt_len);
  assign total      = fem_pkg::SAT_W'(sum) + fem_pkg::SAT_W'(1);
  assign total_sat  = (total > fem_pkg::SAT_W'(fem_pkg::COUNT_MAX)) ?
                      fem_pkg::COUNT_MAX : total[fem_pkg::COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fem_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    act      <= act_next;
    blk      <= blk_next;
    nr       <= nr_next;
    k        <= k_next;
    sum      <= sum_next;
    prev     <= prev_next;
    tgt_idx  <= tgt_idx_next;
    tgt_word <= tgt_word_next;
    res      <= res_next;
  end

  always_comb begin
    state_next    = state;
    act_next      = act;
    blk_next      = blk;
    nr_next       = nr;
    k_next        = k;
    sum_next      = sum;
    prev_next     = prev;
    tgt_idx_next  = tgt_idx;
    tgt_word_next = tgt_word;
    res_next      = res;
    mem_req       = '0;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    unique case (state)
      fem_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_next        = action;
          blk_next        = logical_block;
          nr_next         = fem_pkg::from_phys(new_block);
          sum_next        = '0;
          k_next          = '0;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = '0;
          state_next      = fem_pkg::S_WALK;
        end
      end
      fem_pkg::S_WALK: begin
        if (act == fem_pkg::ACT_LOOKUP) begin
          if (cur_len == '0) begin
            res_next   = '{status: fem_pkg::STAT_NOT_FOUND, phys: '0, count: '0};
            state_next = fem_pkg::S_FINISH;
          end else if (blk_ext < end_ext) begin
            res_next   = '{status: fem_pkg::STAT_OK,
                           phys: fem_pkg::to_phys(hit_addr), count: '0};
            state_next = fem_pkg::S_FINISH;
          end else begin
            sum_next = sum_cur;
            if (k == fem_pkg::LAST_IDX) begin
              res_next   = '{status: fem_pkg::STAT_NOT_FOUND, phys: '0, count: '0};
              state_next = fem_pkg::S_FINISH;
            end else begin
              k_next          = k + fem_pkg::idx_t'(1);
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = k + fem_pkg::idx_t'(1);
            end
          end
        end else begin
          if (k != '0 && prev_len != fem_pkg::CNT_FULL && cur_len == '0) begin
            tgt_idx_next  = k - fem_pkg::idx_t'(1);
            tgt_word_next = prev;
            state_next    = fem_pkg::S_APPLY;
          end else begin
            sum_next  = sum_cur;
            prev_next = rd_data;
            if (k == fem_pkg::LAST_IDX) begin
              if (cur_len != fem_pkg::CNT_FULL) begin
                tgt_idx_next  = k;
                tgt_word_next = rd_data;
                state_next    = fem_pkg::S_APPLY;
              end else begin
                res_next   = '{status: fem_pkg::STAT_NO_ROOM, phys: '0, count: '0};
                state_next = fem_pkg::S_FINISH;
              end
            end else begin
              k_next          = k + fem_pkg::idx_t'(1);
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = k + fem_pkg::idx_t'(1);
            end
          end
        end
      end
      fem_pkg::S_APPLY: begin
        res_next   = '{status: fem_pkg::STAT_OK,
                       phys: fem_pkg::to_phys(nr), count: total_sat};
        state_next = fem_pkg::S_FINISH;
        priority if (nr == '0) begin
          res_next = '{status: fem_pkg::STAT_NO_ROOM, phys: '0, count: '0};
        end else if (tgt_len == '0) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = tgt_idx;
          mem_req.wr_data = fem_pkg::ext_pack(nr, '0);
        end else if (contig_end == {1'b0, nr}) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = tgt_idx;
          mem_req.wr_data = fem_pkg::ext_pack(fem_pkg::ext_start(tgt_word), tgt_len);
        end else if (tgt_idx == fem_pkg::LAST_IDX) begin
          res_next = '{status: fem_pkg::STAT_NO_ROOM, phys: '0, count: '0};
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = tgt_idx + fem_pkg::idx_t'(1);
          mem_req.wr_data = fem_pkg::ext_pack(nr, '0);
        end
      end
      fem_pkg::S_FINISH: begin
        res_valid = 1'b1;
        if (out_free) begin
          state_next = fem_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fem_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/file_extent_map.sv =====
// Top level of the file extent map: sequencer, extent table and output register.
// Depends on fem_pkg, fem_mem and fem_ctrl.
//
// Usage: a request on the input channel (in_valid/in_ready) carries action,
// logical_block and new_block. Action lookup maps logical_block to a physical
// block or reports not found; action append adds new_block to the end of the
// file and reports the new block count, or no room.
// Each request gives exactly one result on the output channel
// (out_valid/out_ready) carrying status, physical_block and block_count.
// The sequencer reads one extent per cycle from the table while it walks;
// an append that finds a target extent then passes through a step that
// writes the extent back before its result reaches the output register.
// Throughput: one request at a time; the next request is taken in the cycle
// after the previous result has moved into the output register.
// The output register holds one finished result, so a new request can be
// taken and walked while that result waits; if the receiver keeps stalling,
// the sequencer holds its second result and takes no further request.
// Reset empties every extent at once and leaves the block idle and ready.
module file_extent_map (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic [fem_pkg::LB_W-1:0]    logical_block,
  input  logic [fem_pkg::PHYS_W-1:0]  new_block,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [fem_pkg::PHYS_W-1:0]  physical_block,
  output logic [fem_pkg::COUNT_W-1:0] block_count
);

  fem_pkg::mem_req_t mem_req;
  fem_pkg::word_t    rd_data;
  fem_pkg::res_t     res;
  logic              res_valid;
  logic              out_free;

  assign out_free = !out_valid || out_ready;

  fem_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  fem_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .logical_block (logical_block),
    .new_block     (new_block),
    .out_free      (out_free),
    .res_valid     (res_valid),
    .res           (res),
    .mem_req       (mem_req),
    .rd_data       (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      status         <= res.status;
      physical_block <= res.phys;
      block_count    <= res.count;
    end
  end

  a_count_on_fail : assert property (@(posedge clk) disable iff (rst)
    out_valid && status != fem_pkg::STAT_OK |-> block_count == '0)
    else $error("nonzero block count on a failed request");

  a_write_when_busy : assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> !in_ready)
    else $error("extent table written while idle");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken during a walk");

  a_result_needs_room : assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_free |=> res_valid)
    else $error("finished result dropped while output register full");

endmodule
